// ----- src/cfdq_pkg.sv -----
// Shared types and constants for the CAN frame check and dispatch block.
// Holds the request/response word structs, operation and status codes.
// No dependencies.
package cfdq_pkg;

   localparam int IDENT_W   = 11;
   localparam int LENGTH_W  = 4;
   localparam int DATA_W    = 64;
   localparam int SPEED_W   = 16;
   localparam int TOTAL_W   = 32;
   localparam int OP_W      = 2;
   localparam int STATUS_W  = 3;
   localparam int CHECKED_BYTES = 7;

   localparam logic [LENGTH_W-1:0] MIN_LENGTH = 4'd8;

   localparam logic [IDENT_W-1:0] SENSOR_IDENT_RESET  = 11'h001;
   localparam logic [IDENT_W-1:0] MACHINE_IDENT_RESET = 11'h002;

   // Register indexes of the csr port
   localparam logic CSR_SENSOR_IDENT  = 1'b0;
   localparam logic CSR_MACHINE_IDENT = 1'b1;

   localparam logic [OP_W-1:0] OP_FRAME       = 2'd0;
   localparam logic [OP_W-1:0] OP_POP_SENSOR  = 2'd1;
   localparam logic [OP_W-1:0] OP_POP_MACHINE = 2'd2;

   localparam logic [STATUS_W-1:0] ST_STORED_SENSOR  = 3'd0;
   localparam logic [STATUS_W-1:0] ST_STORED_MACHINE = 3'd1;
   localparam logic [STATUS_W-1:0] ST_DROPPED_FULL   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_REJECTED       = 3'd3;
   localparam logic [STATUS_W-1:0] ST_POPPED         = 3'd4;
   localparam logic [STATUS_W-1:0] ST_QUEUE_EMPTY    = 3'd5;

   typedef struct packed {
      logic [OP_W-1:0]     operation;
      logic [IDENT_W-1:0]  frame_ident;
      logic                extended_flag;
      logic [LENGTH_W-1:0] length_code;
      logic [DATA_W-1:0]   payload_in;
   } req_word_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [DATA_W-1:0]   payload_out;
      logic [SPEED_W-1:0]  spindle_speed;
      logic [TOTAL_W-1:0]  sensor_total_out;
      logic [TOTAL_W-1:0]  machine_total_out;
   } rsp_word_type;

   typedef struct packed {
      logic full;
      logic empty;
   } ring_flags_type;

endpackage

// ----- src/cfdq_ring.sv -----
// One receive ring queue: entry memory, head/tail pointers, fill and push total.
// Read data of a pop is registered and holds until the next pop.
// Depends on cfdq_pkg.
module cfdq_ring
   import cfdq_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  logic                pop,
   input  logic [DATA_W-1:0]   push_data,
   output ring_flags_type      flags,
   output logic [DATA_W-1:0]   rd_data,
   output logic [TOTAL_W-1:0]  total_in
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [DATA_W-1:0]  store [DEPTH];
   logic [DATA_W-1:0]  rd_data_ff;
   logic [PTR_W-1:0]   head_ff, head_in;
   logic [PTR_W-1:0]   tail_ff, tail_in;
   logic [CNT_W-1:0]   fill_ff, fill_in;
   logic [TOTAL_W-1:0] total_ff;

   assign flags.full  = (fill_ff == CNT_W'(DEPTH));
   assign flags.empty = (fill_ff == '0);

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      fill_in  = fill_ff;
      total_in = total_ff;
      if (push) begin
         tail_in  = (tail_ff == PTR_W'(DEPTH - 1)) ? '0 : tail_ff + 1'b1;
         total_in = total_ff + 1'b1;
      end
      if (pop) begin
         head_in = (head_ff == PTR_W'(DEPTH - 1)) ? '0 : head_ff + 1'b1;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         fill_ff  <= '0;
         total_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         fill_ff  <= fill_in;
         total_ff <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store[tail_ff] <= push_data;
      end
      if (pop) begin
         rd_data_ff <= store[head_ff];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/can_frame_check_and_dispatch_queues.sv -----
// Top level: checks received CAN frames, dispatches them into the sensor
// and machine rings, and serves pops. Depends on cfdq_pkg and cfdq_ring.
//
// Usage:
//   req_ channel carries one word: a received frame (operation 0) or a pop
//   of the sensor (1) or machine (2) ring. rsp_ channel returns exactly one
//   word per request: status, popped entry, spindle speed and both push
//   totals as they stand after that request.
//   csr_ port writes sensor_ident (index 0) or machine_ident (index 1);
//   write it only while no request is in flight.
// Timing:
//   A request is decided and the rings updated in the cycle it is accepted;
//   the ring read and the decision are registered in the middle stage, and
//   the response word is then registered in the output register. One word
//   is taken every cycle while req_stall is low.
// Reset:
//   Rings empty, totals zero, identifiers 1 and 2, no response pending.
// Backpressure:
//   rsp_stall holds the output register; the middle stage still fills, and
//   req_stall rises only once both stages hold a word.
module can_frame_check_and_dispatch_queues
   import cfdq_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  req_word_type        req_payload,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output rsp_word_type        rsp_payload,
   input  logic                csr_write_enable,
   input  logic                csr_index,
   input  logic [IDENT_W-1:0]  csr_write_data
);

   logic [IDENT_W-1:0] sensor_ident_ff;
   logic [IDENT_W-1:0] machine_ident_ff;

   ring_flags_type     sensor_flags, machine_flags;
   logic [DATA_W-1:0]  sensor_rd, machine_rd;
   logic [TOTAL_W-1:0] sensor_total_in, machine_total_in;

   logic               accept;
   logic               advance_out;
   logic               sum_ok;
   logic [7:0]         byte_sum;
   logic               frame_ok;
   logic               match_sensor, match_machine;
   logic               push_sensor, push_machine;
   logic               pop_sensor, pop_machine;
   logic [STATUS_W-1:0] status_in;

   logic               mid_valid_ff;
   logic [STATUS_W-1:0] mid_status_ff;
   logic               mid_pop_sensor_ff;
   logic               mid_pop_machine_ff;
   logic [TOTAL_W-1:0] mid_sensor_total_ff;
   logic [TOTAL_W-1:0] mid_machine_total_ff;

   logic               out_valid_ff;
   rsp_word_type       out_word_ff, out_word_in;

   // Configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         sensor_ident_ff  <= SENSOR_IDENT_RESET;
         machine_ident_ff <= MACHINE_IDENT_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_SENSOR_IDENT:  sensor_ident_ff  <= csr_write_data;
            CSR_MACHINE_IDENT: machine_ident_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // Handshake
   assign advance_out = !out_valid_ff || !rsp_stall;
   assign req_stall   = mid_valid_ff && !advance_out;
   assign accept      = req_valid && !req_stall;

   // Frame check
   always_comb begin
      byte_sum = '0;
      for (int i = 0; i < CHECKED_BYTES; i++) begin
         byte_sum = byte_sum + req_payload.payload_in[8*i +: 8];
      end
   end

   assign sum_ok   = (byte_sum == req_payload.payload_in[8*CHECKED_BYTES +: 8]);
   assign frame_ok = (req_payload.operation == OP_FRAME) && !req_payload.extended_flag
                     && (req_payload.length_code >= MIN_LENGTH) && sum_ok;
   // Equal identifiers: sensor wins
   assign match_sensor  = frame_ok && (req_payload.frame_ident == sensor_ident_ff);
   assign match_machine = frame_ok && !match_sensor
                          && (req_payload.frame_ident == machine_ident_ff);

   assign push_sensor  = accept && match_sensor && !sensor_flags.full;
   assign push_machine = accept && match_machine && !machine_flags.full;
   assign pop_sensor   = accept && (req_payload.operation == OP_POP_SENSOR)
                         && !sensor_flags.empty;
   assign pop_machine  = accept && (req_payload.operation == OP_POP_MACHINE)
                         && !machine_flags.empty;

   always_comb begin
      status_in = ST_REJECTED;
      case (req_payload.operation)
         OP_FRAME: begin
            if (match_sensor) begin
               status_in = sensor_flags.full ? ST_DROPPED_FULL : ST_STORED_SENSOR;
            end else if (match_machine) begin
               status_in = machine_flags.full ? ST_DROPPED_FULL : ST_STORED_MACHINE;
            end
         end
         OP_POP_SENSOR:  status_in = sensor_flags.empty ? ST_QUEUE_EMPTY : ST_POPPED;
         OP_POP_MACHINE: status_in = machine_flags.empty ? ST_QUEUE_EMPTY : ST_POPPED;
         default:        status_in = ST_REJECTED;
      endcase
   end

   cfdq_ring #(
      .DEPTH (QUEUE_DEPTH)
   ) u_sensor_ring (
      .clock     (clock),
      .reset     (reset),
      .push      (push_sensor),
      .pop       (pop_sensor),
      .push_data (req_payload.payload_in),
      .flags     (sensor_flags),
      .rd_data   (sensor_rd),
      .total_in  (sensor_total_in)
   );

   cfdq_ring #(
      .DEPTH (QUEUE_DEPTH)
   ) u_machine_ring (
      .clock     (clock),
      .reset     (reset),
      .push      (push_machine),
      .pop       (pop_machine),
      .push_data (req_payload.payload_in),
      .flags     (machine_flags),
      .rd_data   (machine_rd),
      .total_in  (machine_total_in)
   );

   // Middle stage: decision and total snapshot, waits for the ring read
   always_ff @(posedge clock) begin
      if (reset) begin
         mid_valid_ff <= 1'b0;
      end else if (accept) begin
         mid_valid_ff <= 1'b1;
      end else if (advance_out) begin
         mid_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mid_status_ff        <= status_in;
         mid_pop_sensor_ff    <= pop_sensor;
         mid_pop_machine_ff   <= pop_machine;
         mid_sensor_total_ff  <= sensor_total_in;
         mid_machine_total_ff <= machine_total_in;
      end
   end

   always_comb begin
      out_word_in                   = '0;
      out_word_in.status            = mid_status_ff;
      out_word_in.sensor_total_out  = mid_sensor_total_ff;
      out_word_in.machine_total_out = mid_machine_total_ff;
      if (mid_pop_sensor_ff) begin
         out_word_in.payload_out = sensor_rd;
      end else if (mid_pop_machine_ff) begin
         out_word_in.payload_out   = machine_rd;
         out_word_in.spindle_speed = {machine_rd[7:0], machine_rd[15:8]};
      end
   end

   // Output register: hold while stalled
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance_out) begin
         out_valid_ff <= mid_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance_out && mid_valid_ff) begin
         out_word_ff <= out_word_in;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_word_ff;

endmodule

// ----- dv/tb.sv -----
// Self-checking testbench for can_frame_check_and_dispatch_queues.
// Drives frames and pops, predicts each response word with a local copy of both rings.
// Depends on cfdq_pkg and the block's RTL only.
module tb;
   import cfdq_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int RING_DEPTH  = 16;
   localparam int CYCLE_LIMIT = 400_000;
   localparam int DRAIN_WAIT  = 10;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   req_word_type        req_payload = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   rsp_word_type        rsp_payload;
   logic                csr_write_enable = 1'b0;
   logic                csr_index = CSR_SENSOR_IDENT;
   logic [IDENT_W-1:0]  csr_write_data = '0;

   // local copy of the block's state
   logic [IDENT_W-1:0]  sensor_ident_cfg = SENSOR_IDENT_RESET;
   logic [IDENT_W-1:0]  machine_ident_cfg = MACHINE_IDENT_RESET;
   logic [DATA_W-1:0]   sensor_ring[$];
   logic [DATA_W-1:0]   machine_ring[$];
   logic [TOTAL_W-1:0]  sensor_total = '0;
   logic [TOTAL_W-1:0]  machine_total = '0;

   req_word_type        frame_backlog[$];
   rsp_word_type        outcome_queue[$];
   bit                  sender_idles = 1'b1;
   bit                  receiver_idles = 1'b1;
   int                  gap_left = 0;
   int                  stall_left = 0;
   int                  mismatch_count = 0;
   int                  cycle_count = 0;
   bit                  accepted;
   rsp_word_type        want;

   can_frame_check_and_dispatch_queues #(.QUEUE_DEPTH(RING_DEPTH)) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic logic [7:0] byte_sum7(logic [DATA_W-1:0] data);
      logic [7:0] sum;
      sum = '0;
      for (int i = 0; i < CHECKED_BYTES; i++) sum += data[8*i +: 8];
      return sum;
   endfunction

   function automatic rsp_word_type dispatch_outcome(req_word_type w);
      rsp_word_type r;
      logic         well_formed;
      r = '0;
      r.status = ST_REJECTED;
      well_formed = !w.extended_flag && w.length_code >= MIN_LENGTH &&
                    w.payload_in[63:56] == byte_sum7(w.payload_in);
      case (w.operation)
         OP_FRAME: begin
            // sensor match wins when both identifiers are equal
            if (well_formed && w.frame_ident == sensor_ident_cfg) begin
               if (sensor_ring.size() < RING_DEPTH) begin
                  sensor_ring.push_back(w.payload_in);
                  sensor_total++;
                  r.status = ST_STORED_SENSOR;
               end else begin
                  r.status = ST_DROPPED_FULL;
               end
            end else if (well_formed && w.frame_ident == machine_ident_cfg) begin
               if (machine_ring.size() < RING_DEPTH) begin
                  machine_ring.push_back(w.payload_in);
                  machine_total++;
                  r.status = ST_STORED_MACHINE;
               end else begin
                  r.status = ST_DROPPED_FULL;
               end
            end
         end
         OP_POP_SENSOR: begin
            if (sensor_ring.size() > 0) begin
               r.status = ST_POPPED;
               r.payload_out = sensor_ring.pop_front();
            end else begin
               r.status = ST_QUEUE_EMPTY;
            end
         end
         OP_POP_MACHINE: begin
            if (machine_ring.size() > 0) begin
               r.status = ST_POPPED;
               r.payload_out = machine_ring.pop_front();
               r.spindle_speed = {r.payload_out[7:0], r.payload_out[15:8]};
            end else begin
               r.status = ST_QUEUE_EMPTY;
            end
         end
         default: ;
      endcase
      r.sensor_total_out = sensor_total;
      r.machine_total_out = machine_total;
      return r;
   endfunction

   // mostly back to back, some short gaps, a few long ones
   function automatic int idle_length(bit enabled);
      int pick;
      if (!enabled) return 0;
      pick = $urandom_range(99);
      if (pick < 65) return 0;
      if (pick < 93) return $urandom_range(3, 1);
      return $urandom_range(25, 6);
   endfunction

   function automatic req_word_type good_frame(logic [IDENT_W-1:0] ident,
                                               logic [LENGTH_W-1:0] length,
                                               logic [DATA_W-1:0] data);
      req_word_type w;
      w.operation = OP_FRAME;
      w.frame_ident = ident;
      w.extended_flag = 1'b0;
      w.length_code = length;
      w.payload_in = data;
      w.payload_in[63:56] = byte_sum7(data);
      return w;
   endfunction

   function automatic req_word_type pop_word(logic [OP_W-1:0] op);
      req_word_type w;
      w.operation = op;
      w.frame_ident = IDENT_W'($urandom_range(2047));
      w.extended_flag = 1'($urandom_range(1));
      w.length_code = LENGTH_W'($urandom_range(15));
      w.payload_in = {$urandom, $urandom};
      return w;
   endfunction

   function automatic req_word_type random_word(int push_pct, int pop_pct);
      req_word_type w;
      int           pick;
      pick = $urandom_range(99);
      w = pop_word(OP_FRAME);
      if (pick < push_pct) begin
         w = good_frame($urandom_range(1) ? sensor_ident_cfg : machine_ident_cfg,
                        LENGTH_W'($urandom_range(15, 8)), {$urandom, $urandom});
      end else if (pick < push_pct + pop_pct) begin
         w.operation = $urandom_range(1) ? OP_POP_SENSOR : OP_POP_MACHINE;
      end else if (pick < push_pct + pop_pct + 8) begin
         // well-formed frame with exactly one defect
         w = good_frame($urandom_range(1) ? sensor_ident_cfg : machine_ident_cfg,
                        LENGTH_W'($urandom_range(15, 8)), {$urandom, $urandom});
         case ($urandom_range(3))
            0: w.extended_flag = 1'b1;
            1: w.length_code = LENGTH_W'($urandom_range(7));
            2: w.payload_in[63:56] ^= 8'($urandom_range(255, 1));
            default: begin
               while (w.frame_ident == sensor_ident_cfg ||
                      w.frame_ident == machine_ident_cfg)
                  w.frame_ident = IDENT_W'($urandom_range(2047));
            end
         endcase
      end else begin
         w.operation = OP_W'($urandom_range(3));
      end
      return w;
   endfunction

   task automatic note_mismatch(string msg);
      mismatch_count++;
      if (mismatch_count <= 10) $display("mismatch: %s", msg);
   endtask

   // wait until every word is accepted and answered, then let the pipe settle
   task automatic wait_idle();
      do @(negedge clock);
      while (frame_backlog.size() != 0 || req_valid || outcome_queue.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_idents(logic [IDENT_W-1:0] s_ident, logic [IDENT_W-1:0] m_ident);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= CSR_SENSOR_IDENT;
      csr_write_data <= s_ident;
      @(posedge clock);
      csr_index <= CSR_MACHINE_IDENT;
      csr_write_data <= m_ident;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      sensor_ident_cfg = s_ident;
      machine_ident_cfg = m_ident;
      @(negedge clock);
   endtask

   task automatic run_phase(logic [IDENT_W-1:0] s_ident, logic [IDENT_W-1:0] m_ident,
                            int count, int push_pct, int pop_pct, bit s_idle, bit r_idle);
      wait_idle();
      write_idents(s_ident, m_ident);
      sender_idles = s_idle;
      receiver_idles = r_idle;
      for (int i = 0; i < count; i++) frame_backlog.push_back(random_word(push_pct, pop_pct));
   endtask

   task automatic load_directed();
      req_word_type w;
      frame_backlog.push_back(pop_word(OP_POP_SENSOR));
      frame_backlog.push_back(pop_word(OP_POP_MACHINE));
      w = '1;
      frame_backlog.push_back(w);
      w = '0;
      w.operation = 2'b11;
      frame_backlog.push_back(w);
      frame_backlog.push_back(good_frame(SENSOR_IDENT_RESET, 4'd8, '0));
      frame_backlog.push_back(good_frame(MACHINE_IDENT_RESET, 4'd15, 64'h00FF_FFFF_FFFF_FFFF));
      w = good_frame(SENSOR_IDENT_RESET, 4'd8, {$urandom, $urandom});
      w.extended_flag = 1'b1;
      frame_backlog.push_back(w);
      frame_backlog.push_back(good_frame(SENSOR_IDENT_RESET, 4'd7, {$urandom, $urandom}));
      frame_backlog.push_back(good_frame(MACHINE_IDENT_RESET, 4'd0, {$urandom, $urandom}));
      w = good_frame(SENSOR_IDENT_RESET, 4'd9, {$urandom, $urandom});
      w.payload_in[63:56] = ~w.payload_in[63:56];
      frame_backlog.push_back(w);
      frame_backlog.push_back(good_frame(11'h000, 4'd8, {$urandom, $urandom}));
      frame_backlog.push_back(good_frame(11'h7FF, 4'd8, {$urandom, $urandom}));
      frame_backlog.push_back(good_frame(11'h003, 4'd8, {$urandom, $urandom}));
      frame_backlog.push_back(pop_word(OP_POP_MACHINE));
      frame_backlog.push_back(pop_word(OP_POP_SENSOR));
      frame_backlog.push_back(good_frame(MACHINE_IDENT_RESET, 4'd12, {$urandom, $urandom}));
      frame_backlog.push_back(pop_word(OP_POP_MACHINE));
      frame_backlog.push_back(pop_word(OP_POP_SENSOR));
      frame_backlog.push_back(pop_word(OP_POP_MACHINE));
      frame_backlog.push_back(good_frame(SENSOR_IDENT_RESET, 4'd8, {$urandom, $urandom}));
      frame_backlog.push_back(pop_word(OP_POP_SENSOR));
   endtask

   // request driver: predict on acceptance, then present the next word
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         accepted = req_valid && !req_stall;
         if (accepted) outcome_queue.push_back(dispatch_outcome(req_payload));
         if (accepted || !req_valid) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (frame_backlog.size() > 0) begin
               req_payload <= frame_backlog.pop_front();
               req_valid <= 1'b1;
               gap_left = idle_length(sender_idles);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response monitor and stall generator
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (outcome_queue.size() == 0) begin
               note_mismatch($sformatf("response word with none expected: %h", rsp_payload));
            end else begin
               want = outcome_queue.pop_front();
               if (rsp_payload.status !== want.status)
                  note_mismatch($sformatf("status expected %0d, got %0d",
                                          want.status, rsp_payload.status));
               if (rsp_payload.payload_out !== want.payload_out)
                  note_mismatch($sformatf("payload_out expected %h, got %h",
                                          want.payload_out, rsp_payload.payload_out));
               if (rsp_payload.spindle_speed !== want.spindle_speed)
                  note_mismatch($sformatf("spindle_speed expected %h, got %h",
                                          want.spindle_speed, rsp_payload.spindle_speed));
               if (rsp_payload.sensor_total_out !== want.sensor_total_out)
                  note_mismatch($sformatf("sensor_total_out expected %0d, got %0d",
                                          want.sensor_total_out, rsp_payload.sensor_total_out));
               if (rsp_payload.machine_total_out !== want.machine_total_out)
                  note_mismatch($sformatf("machine_total_out expected %0d, got %0d",
                                          want.machine_total_out,
                                          rsp_payload.machine_total_out));
            end
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
            stall_left = idle_length(receiver_idles);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      load_directed();
      wait_idle();
      sender_idles = 1'b1;
      receiver_idles = 1'b1;
      for (int i = 0; i < 300; i++) frame_backlog.push_back(random_word(55, 30));
      // push heavy at full rate: fill both rings and hit drops
      run_phase(11'h000, 11'h7FF, 300, 70, 15, 1'b0, 1'b0);
      run_phase(11'h5A5, 11'h5A5, 250, 45, 40, 1'b0, 1'b1);
      // pop heavy: drain to empty
      run_phase(11'h7FF, 11'h000, 300, 20, 65, 1'b1, 1'b0);
      run_phase(IDENT_W'($urandom_range(2047)), IDENT_W'($urandom_range(2047)),
                350, 50, 35, 1'b1, 1'b1);
      run_phase(IDENT_W'($urandom_range(2047)), IDENT_W'($urandom_range(2047)),
                400, 50, 35, 1'b1, 1'b1);
      wait_idle();
      repeat (DRAIN_WAIT) @(posedge clock);
      if (mismatch_count == 0 && outcome_queue.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
